>>> rtl/rtd_code_to_temperature_top_defines.svh
// ----------------------------------------------------------------------------
// RTD linearizer assertion macros
// Shared helpers for concurrent checks clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RTD_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH
`define RTD_CODE_TO_TEMPERATURE_TOP_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define RTD_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rtd linearizer check failed");

// Checks a consequence in the cycle after its antecedent.
`define RTD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rtd linearizer check failed");

`endif

>>> rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// RTD linearizer package
// Shared widths, constants and types for the code to temperature pipeline.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int CODE_BITS = 24;
    localparam int FRAC_BITS = 10;

    localparam int IN_W    = ((CODE_BITS + 7) / 8) * 8;
    localparam int TC_W    = FRAC_BITS + 11;
    localparam int TF_W    = FRAC_BITS + 12;
    localparam int OUT_RAW = 32 + TC_W + TF_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam int DIFF_W = ((CODE_BITS > 24) ? CODE_BITS : 24) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int DIV_W  = 30;
    localparam int R0_W   = 24;
    localparam int X_W    = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [TC_W-1:0] TC_MAX = TC_W'(850 * (2 ** FRAC_BITS));
    localparam logic signed [TC_W-1:0] TC_MIN = -TC_W'(200 * (2 ** FRAC_BITS));
    localparam logic signed [TF_W-1:0] TF_MAX = TF_W'(1562 * (2 ** FRAC_BITS));
    localparam logic signed [TF_W-1:0] TF_MIN = -TF_W'(328 * (2 ** FRAC_BITS));

    typedef struct packed {
        logic signed [23:0] offset_code;
        logic [2:0]         gain_log2;
        logic [31:0]        fsr;
        logic [22:0]        fsc;
        logic [23:0]        r0;
        logic [31:0]        coeff_a;
        logic signed [31:0] coeff_b;
    } t_cfg;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic [31:0]            res;
        logic signed [X_W-1:0]  xq;
        logic                   hot;
        logic                   flag;
    } t_scaled;

    typedef struct packed {
        logic [31:0]            res;
        logic signed [TC_W-1:0] tc;
        logic signed [TF_W-1:0] tf;
        logic                   flag;
    } t_result;

endpackage

>>> rtl/rtd_front.sv
// ----------------------------------------------------------------------------
// RTD front stage
// Accepts raw codes, removes the offset and tags negative results.
// ----------------------------------------------------------------------------
module rtd_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [rtd_pkg::IN_W-1:0] i_data,
    input  rtd_pkg::t_cfg            i_cfg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output rtd_pkg::t_item           o_item
);
    import rtd_pkg::*;

    logic                     r_valid;
    t_item                    r_item;
    t_item                    n_item;
    logic signed [DIFF_W-1:0] diff;

    assign diff = DIFF_W'($signed(i_data[CODE_BITS-1:0])) - DIFF_W'($signed(i_cfg.offset_code));

    always_comb begin
        n_item.neg = diff[DIFF_W-1];
        n_item.mag = diff[DIFF_W-1] ? '0 : diff[MAG_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

>>> rtl/rtd_fifo.sv
// ----------------------------------------------------------------------------
// RTD item queue
// Small queue between the front stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rtd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  rtd_pkg::t_item i_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output rtd_pkg::t_item o_item
);
    import rtd_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               push;
    logic               pop;

    assign o_push_ready = r_cnt != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_item       = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> rtl/rtd_scale.sv
// ----------------------------------------------------------------------------
// RTD resistance scaler
// Scales the code to resistance and forms the normalized deviation from R0.
// ----------------------------------------------------------------------------
module rtd_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rtd_pkg::t_item   i_item,
    input  rtd_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output rtd_pkg::t_scaled o_data
);
    import rtd_pkg::*;

    localparam int PROD_W = MAG_W + 32;
    localparam int RQ_W   = 32;
    localparam int XQ_W   = 31;
    localparam int X_FRAC = 24;
    localparam int XSH    = XQ_W - X_FRAC;
    localparam int NV     = RQ_W + XQ_W + 4;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [RQ_W-1:0]  acc;
        logic             sat;
        logic             flag;
    } t_rdiv;

    typedef struct packed {
        logic [R0_W-1:0] rem;
        logic [XQ_W-1:0] acc;
        logic [31:0]     res;
        logic            hot;
        logic            sat;
        logic            flag;
    } t_xdiv;

    logic [NV-1:0]     r_pv;
    logic [PROD_W-1:0] r_prod;
    logic              r_flag1;
    t_rdiv             r_rd [RQ_W+1];
    t_xdiv             r_xd [XQ_W+1];
    t_scaled           r_out;

    logic [22:0]       fsc;
    logic [DIV_W-1:0]  divisor;
    logic [R0_W-1:0]   r0;
    logic [MAG_W-1:0]  hi;
    t_rdiv             n_rd0;
    t_xdiv             n_xd0;
    t_scaled           n_out;
    logic [31:0]       res;
    logic signed [33:0] nd;
    logic [32:0]       nmag;
    logic              over;
    logic [XQ_W-1:0]   qm;

    assign fsc     = (i_cfg.fsc == 23'd0) ? 23'd1 : i_cfg.fsc;
    assign divisor = DIV_W'(fsc) << i_cfg.gain_log2;
    assign r0      = (i_cfg.r0 == '0) ? R0_W'(1) : i_cfg.r0;

    assign o_valid = r_pv[NV-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_en) begin
            r_pv <= {r_pv[NV-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(i_item.mag) * PROD_W'(i_cfg.fsr);
            r_flag1 <= i_item.neg;
        end
    end

    always_comb begin
        hi         = r_prod[PROD_W-1:32];
        n_rd0.sat  = 32'(hi) >= 32'(divisor);
        n_rd0.rem  = n_rd0.sat ? '0 : DIV_W'(hi);
        n_rd0.acc  = n_rd0.sat ? '0 : r_prod[31:0];
        n_rd0.flag = r_flag1 || n_rd0.sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd[0] <= n_rd0;
        end
    end

    for (genvar k = 0; k < RQ_W; k++) begin : g_rdiv
        logic [DIV_W:0] trial;
        t_rdiv          n_rd;
        always_comb begin
            trial = {r_rd[k].rem, r_rd[k].acc[RQ_W-1]};
            n_rd  = r_rd[k];
            if (trial >= {1'b0, divisor}) begin
                n_rd.rem = DIV_W'(trial - {1'b0, divisor});
                n_rd.acc = {r_rd[k].acc[RQ_W-2:0], 1'b1};
            end else begin
                n_rd.rem = trial[DIV_W-1:0];
                n_rd.acc = {r_rd[k].acc[RQ_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rd[k+1] <= n_rd;
            end
        end
    end

    always_comb begin
        res        = r_rd[RQ_W].sat ? 32'hFFFF_FFFF : r_rd[RQ_W].acc;
        nd         = 34'(r0) - 34'(res);
        nmag       = nd[33] ? 33'(-nd) : nd[32:0];
        n_xd0.res  = res;
        n_xd0.hot  = nd[33];
        n_xd0.sat  = nmag >= 33'({r0, XSH'(0)});
        n_xd0.rem  = n_xd0.sat ? '0 : R0_W'(nmag >> XSH);
        n_xd0.acc  = n_xd0.sat ? '0 : {nmag[XSH-1:0], X_FRAC'(0)};
        n_xd0.flag = r_rd[RQ_W].flag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0] <= n_xd0;
        end
    end

    for (genvar k = 0; k < XQ_W; k++) begin : g_xdiv
        logic [R0_W:0] trial;
        t_xdiv         n_xd;
        always_comb begin
            trial = {r_xd[k].rem, r_xd[k].acc[XQ_W-1]};
            n_xd  = r_xd[k];
            if (trial >= {1'b0, r0}) begin
                n_xd.rem = R0_W'(trial - {1'b0, r0});
                n_xd.acc = {r_xd[k].acc[XQ_W-2:0], 1'b1};
            end else begin
                n_xd.rem = trial[R0_W-1:0];
                n_xd.acc = {r_xd[k].acc[XQ_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xd[k+1] <= n_xd;
            end
        end
    end

    always_comb begin
        over       = r_xd[XQ_W].sat || (r_xd[XQ_W].acc > XQ_W'(2 ** 30));
        qm         = over ? XQ_W'(2 ** 30) : r_xd[XQ_W].acc;
        n_out.res  = r_xd[XQ_W].res;
        n_out.hot  = r_xd[XQ_W].hot;
        n_out.xq   = r_xd[XQ_W].hot ? -X_W'(qm) : X_W'(qm);
        n_out.flag = r_xd[XQ_W].flag || over;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/rtd_temp.sv
// ----------------------------------------------------------------------------
// RTD temperature solver
// Inverts the Callendar-Van Dusen quadratic and converts to Fahrenheit.
// ----------------------------------------------------------------------------
module rtd_temp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rtd_pkg::t_scaled i_data,
    input  rtd_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output rtd_pkg::t_result o_data
);
    import rtd_pkg::*;

    localparam int DISC_W = 58;
    localparam int SQ_W   = DISC_W / 2;
    localparam int SQ_R_W = SQ_W + 2;
    localparam int TQ_W   = FRAC_BITS + 11;
    localparam int TQ_SH  = TQ_W - 5 - FRAC_BITS;
    localparam int F_M_W  = TC_W + 2;
    localparam int F_K    = FRAC_BITS + 16;
    localparam longint F_C = ((longint'(1) << F_K) + 4) / 5;
    localparam int F_C_W  = F_K - 2;
    localparam int F_P_W  = F_M_W + F_C_W;
    localparam int SQ0    = 2;
    localparam int DD0    = SQ0 + SQ_W + 1;
    localparam int NV     = DD0 + TQ_W + 5;
    localparam logic [TQ_W-1:0] TQ_MAX = TQ_W'(TC_MAX);
    localparam logic [TQ_W-1:0] TQ_MIN = TQ_W'(-TC_MIN);

    typedef struct packed {
        logic [SQ_R_W-1:0] rem;
        logic [SQ_W-1:0]   root;
        logic [DISC_W-1:0] rad;
        logic              dneg;
        t_scaled           s;
    } t_sq;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [TQ_W-1:0]  acc;
        logic [DIV_W-1:0] den;
        logic             dneg;
        logic             zero;
        logic             tsat;
        logic             pos;
        t_scaled          s;
    } t_dd;

    typedef struct packed {
        logic signed [TC_W-1:0] tc;
        logic [31:0]            res;
        logic                   flag;
    } t_fin;

    logic [NV-1:0]            r_pv;
    logic [55:0]              r_asq;
    logic signed [63:0]       r_bx;
    t_scaled                  r_s1;
    logic [55:0]              r_asq2;
    logic signed [DISC_W-1:0] r_bq;
    t_scaled                  r_s2;
    t_sq                      r_sq [SQ_W+1];
    t_dd                      r_dd [TQ_W+1];
    t_fin                     r_f1;
    logic [F_M_W-1:0]         r_m;
    logic                     r_neg2;
    t_fin                     r_f2;
    logic [F_P_W-1:0]         r_p;
    logic                     r_neg3;
    t_fin                     r_f3;
    t_result                  r_out;

    logic [63:0]              aa;
    logic signed [63:0]       bq_full;
    logic signed [DISC_W-1:0] disc;
    t_sq                      n_sq0;
    t_dd                      n_dd0;
    logic [DIV_W-1:0]         den;
    logic [X_W-2:0]           xmag;
    t_fin                     n_f1;
    logic [TC_W-1:0]          tabs;
    logic [TF_W-1:0]          q5;

    assign o_valid = r_pv[NV-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_en) begin
            r_pv <= {r_pv[NV-2:0], i_valid};
        end
    end

    assign aa      = 64'(i_cfg.coeff_a) * 64'(i_cfg.coeff_a);
    assign bq_full = r_bx[63] ? ((r_bx + 64'sd16383) >>> 14) : (r_bx >>> 14);
    assign disc    = $signed(DISC_W'(r_asq2)) - r_bq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_asq  <= aa[63:8];
            r_bx   <= 64'(i_data.xq) * 64'(i_cfg.coeff_b);
            r_s1   <= i_data;
            r_asq2 <= r_asq;
            r_bq   <= DISC_W'(bq_full);
            r_s2   <= r_s1;
        end
    end

    always_comb begin
        n_sq0.rem  = '0;
        n_sq0.root = '0;
        n_sq0.dneg = disc[DISC_W-1];
        n_sq0.rad  = disc[DISC_W-1] ? '0 : disc;
        n_sq0.s    = r_s2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0] <= n_sq0;
        end
    end

    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        logic [SQ_R_W+1:0] trial;
        logic [SQ_R_W+1:0] probe;
        t_sq               n_sq;
        always_comb begin
            trial = {r_sq[k].rem, r_sq[k].rad[DISC_W-1:DISC_W-2]};
            probe = (SQ_R_W + 2)'({r_sq[k].root, 2'b01});
            n_sq  = r_sq[k];
            n_sq.rad = {r_sq[k].rad[DISC_W-3:0], 2'b00};
            if (trial >= probe) begin
                n_sq.rem  = SQ_R_W'(trial - probe);
                n_sq.root = {r_sq[k].root[SQ_W-2:0], 1'b1};
            end else begin
                n_sq.rem  = trial[SQ_R_W-1:0];
                n_sq.root = {r_sq[k].root[SQ_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1] <= n_sq;
            end
        end
    end

    always_comb begin
        den        = DIV_W'(i_cfg.coeff_a >> 4) + DIV_W'(r_sq[SQ_W].root);
        xmag       = r_sq[SQ_W].s.xq[X_W-1] ? (X_W - 1)'(-r_sq[SQ_W].s.xq)
                                            : r_sq[SQ_W].s.xq[X_W-2:0];
        n_dd0.den  = den;
        n_dd0.dneg = r_sq[SQ_W].dneg;
        n_dd0.zero = xmag == '0;
        n_dd0.pos  = r_sq[SQ_W].s.xq[X_W-1];
        n_dd0.tsat = (DIV_W + TQ_SH)'(xmag) >= {den, TQ_SH'(0)};
        n_dd0.rem  = n_dd0.tsat ? '0 : DIV_W'(xmag >> TQ_SH);
        n_dd0.acc  = n_dd0.tsat ? '0 : {xmag[TQ_SH-1:0], (TQ_W - TQ_SH)'(0)};
        n_dd0.s    = r_sq[SQ_W].s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd[0] <= n_dd0;
        end
    end

    for (genvar k = 0; k < TQ_W; k++) begin : g_tdiv
        logic [DIV_W:0] trial;
        t_dd            n_dd;
        always_comb begin
            trial = {r_dd[k].rem, r_dd[k].acc[TQ_W-1]};
            n_dd  = r_dd[k];
            if (trial >= {1'b0, r_dd[k].den}) begin
                n_dd.rem = DIV_W'(trial - {1'b0, r_dd[k].den});
                n_dd.acc = {r_dd[k].acc[TQ_W-2:0], 1'b1};
            end else begin
                n_dd.rem = trial[DIV_W-1:0];
                n_dd.acc = {r_dd[k].acc[TQ_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[k+1] <= n_dd;
            end
        end
    end

    always_comb begin
        n_f1.res  = r_dd[TQ_W].s.res;
        n_f1.flag = r_dd[TQ_W].s.flag;
        if (r_dd[TQ_W].dneg) begin
            n_f1.tc   = r_dd[TQ_W].s.hot ? TC_MAX : TC_MIN;
            n_f1.flag = 1'b1;
        end else if (r_dd[TQ_W].zero) begin
            n_f1.tc = '0;
        end else if (r_dd[TQ_W].pos) begin
            if (r_dd[TQ_W].tsat || r_dd[TQ_W].acc > TQ_MAX) begin
                n_f1.tc   = TC_MAX;
                n_f1.flag = 1'b1;
            end else begin
                n_f1.tc = TC_W'(r_dd[TQ_W].acc);
            end
        end else begin
            if (r_dd[TQ_W].tsat || r_dd[TQ_W].acc > TQ_MIN) begin
                n_f1.tc   = TC_MIN;
                n_f1.flag = 1'b1;
            end else begin
                n_f1.tc = -TC_W'(r_dd[TQ_W].acc);
            end
        end
    end

    assign tabs = r_f1.tc[TC_W-1] ? TC_W'(-r_f1.tc) : r_f1.tc;
    assign q5   = TF_W'(r_p >> F_K);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1   <= n_f1;
            r_m    <= F_M_W'({tabs, 3'b000}) + F_M_W'(tabs);
            r_neg2 <= r_f1.tc[TC_W-1];
            r_f2   <= r_f1;
            r_p    <= F_P_W'(r_m) * F_P_W'(F_C);
            r_neg3 <= r_neg2;
            r_f3   <= r_f2;
            r_out.res  <= r_f3.res;
            r_out.tc   <= r_f3.tc;
            r_out.flag <= r_f3.flag;
            r_out.tf   <= (r_neg3 ? -q5 : q5) + TF_W'(32 * (2 ** FRAC_BITS));
        end
    end

endmodule

>>> rtl/rtd_code_to_temperature_top.sv
// ----------------------------------------------------------------------------
// RTD code to temperature linearizer, top level
// Configuration registers, front stage, queue, arithmetic pipeline, output.
// ----------------------------------------------------------------------------
// The block takes one ADC code per clock while the output is not stalled and
// returns one result per code, in order. Its arithmetic is made of the
// bit-per-stage resistance and deviation dividers, the two-bit-per-stage
// square root and the temperature divider, all fully pipelined. A four-entry
// queue decouples the input side from the pipeline, and the whole pipeline
// holds while a finished result waits on the output.
// Registers must be written only while no sample is in flight.
module rtd_code_to_temperature_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // raw_code
    input  logic [rtd_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // resistance, temp_celsius, temp_fahrenheit
    output logic [rtd_pkg::OUT_W-1:0] m_axis_tdata,
    // out_of_range
    output logic                      m_axis_tuser
);
    import rtd_pkg::*;

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_GAIN   = 3'd1;
    localparam logic [2:0] REG_FSR    = 3'd2;
    localparam logic [2:0] REG_FSC    = 3'd3;
    localparam logic [2:0] REG_R0     = 3'd4;
    localparam logic [2:0] REG_A      = 3'd5;
    localparam logic [2:0] REG_B      = 3'd6;

    t_cfg     r_cfg;
    logic     r_out_v;
    t_result  r_out;
    logic     cfg_wr;
    logic     en;
    logic     fr_valid;
    logic     fr_ready;
    t_item    fr_item;
    logic     q_valid;
    t_item    q_item;
    logic     sc_valid;
    t_scaled  sc_data;
    logic     tp_valid;
    t_result  tp_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_code <= 24'sd0;
            r_cfg.gain_log2   <= 3'd0;
            r_cfg.fsr         <= 32'd3317760;
            r_cfg.fsc         <= 23'd8388607;
            r_cfg.r0          <= 24'd102400;
            r_cfg.coeff_a     <= 32'd16786021;
            r_cfg.coeff_b     <= -32'sd162551799;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_OFFSET: r_cfg.offset_code <= pwdata[23:0];
                REG_GAIN:   r_cfg.gain_log2   <= pwdata[2:0];
                REG_FSR:    r_cfg.fsr         <= pwdata;
                REG_FSC:    r_cfg.fsc         <= pwdata[22:0];
                REG_R0:     r_cfg.r0          <= pwdata[23:0];
                REG_A:      r_cfg.coeff_a     <= pwdata;
                REG_B:      r_cfg.coeff_b     <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OFFSET: prdata = 32'(r_cfg.offset_code);
            REG_GAIN:   prdata = 32'(r_cfg.gain_log2);
            REG_FSR:    prdata = r_cfg.fsr;
            REG_FSC:    prdata = 32'(r_cfg.fsc);
            REG_R0:     prdata = 32'(r_cfg.r0);
            REG_A:      prdata = r_cfg.coeff_a;
            REG_B:      prdata = r_cfg.coeff_b;
            default:    prdata = '0;
        endcase
    end

    rtd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_item  (fr_item)
    );

    rtd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_item       (fr_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (en),
        .o_item       (q_item)
    );

    assign en = !r_out_v || m_axis_tready;

    rtd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_item  (q_item),
        .i_cfg   (r_cfg),
        .o_valid (sc_valid),
        .o_data  (sc_data)
    );

    rtd_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_valid),
        .i_data  (sc_data),
        .i_cfg   (r_cfg),
        .o_valid (tp_valid),
        .o_data  (tp_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= tp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= tp_data;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'({r_out.tf, r_out.tc, r_out.res});
    assign m_axis_tuser  = r_out.flag;

endmodule

>>> rtl/rtd_checker.sv
// ----------------------------------------------------------------------------
// RTD linearizer output checker
// Watches the result stream of the top level for stability under back-pressure, range and flag consistency.
// ----------------------------------------------------------------------------
`include "rtd_code_to_temperature_top_defines.svh"

module rtd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_tvalid,
    input logic                      i_tready,
    input logic [rtd_pkg::OUT_W-1:0] i_tdata,
    input logic                      i_tuser
);
    import rtd_pkg::*;

    `RTD_ASSERT_NEXT(a_hold, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata) && $stable(i_tuser))
    `RTD_ASSERT_NOW(a_tc_range, i_tvalid, ($signed(i_tdata[32 +: TC_W]) >= TC_MIN) && ($signed(i_tdata[32 +: TC_W]) <= TC_MAX))
    `RTD_ASSERT_NOW(a_tf_range, i_tvalid, ($signed(i_tdata[32 + TC_W +: TF_W]) >= TF_MIN) && ($signed(i_tdata[32 + TC_W +: TF_W]) <= TF_MAX))
    `RTD_ASSERT_NOW(a_sat_flag, i_tvalid && (i_tdata[31:0] == 32'hFFFF_FFFF), i_tuser)

endmodule

bind rtd_code_to_temperature_top rtd_checker u_rtd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata),
    .i_tuser  (m_axis_tuser)
);
